// File: sv/tlw_pkg.sv
// Shared constants, types and placement function of the two-level timing wheel.
// Used by the interfaces, the result emitter, the top level and the testbench files. No dependencies.
package tlw_pkg;

  localparam int FINE_SLOTS_LOG = 7;
  localparam int COARSE_SLOTS   = 128;
  localparam int TIMER_COUNT    = 32;

  localparam int FUNC_W = 2;
  localparam int ID_W   = 5;
  localparam int PER_W  = 14;

  localparam int FINE_SIZE = 1 << FINE_SLOTS_LOG;
  localparam int SPAN      = FINE_SIZE * COARSE_SLOTS;
  localparam int CW        = $clog2(COARSE_SLOTS);
  localparam int SLOT_W    = (FINE_SLOTS_LOG > CW) ? FINE_SLOTS_LOG : CW;
  localparam int TIDX_W    = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CNT_W     = $clog2(TIMER_COUNT + 1);
  localparam int IDX_EXT_W = (ID_W > TIDX_W) ? ID_W + 1 : TIDX_W + 1;
  localparam int S_W       = ((PER_W > FINE_SLOTS_LOG) ? PER_W : FINE_SLOTS_LOG) + 1;
  localparam int SUM_W     = ((S_W > CW) ? S_W : CW) + 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START = 2'd0,
    FUNC_STOP  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_t;

  // One timer record as kept in the record memory.
  typedef struct packed {
    logic [PER_W-1:0]          reload;
    logic                      in_coarse;
    logic [SLOT_W-1:0]         slot;
    logic [FINE_SLOTS_LOG-1:0] fine_off;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic            push;
    logic [ID_W-1:0] id;
    logic            flush;
  } emit_req_t;

  typedef struct packed {
    logic push_ready;
    logic pend_valid;
  } emit_sts_t;

  function automatic logic period_ok(logic [PER_W-1:0] p);
    return (p != '0) && (32'(p) < 32'(SPAN));
  endfunction

  // Computes where a timer with period p lands relative to the cursors.
  function automatic rec_t place(logic [PER_W-1:0] p,
                                 logic [FINE_SLOTS_LOG-1:0] fc,
                                 logic [CW-1:0] cc);
    logic [S_W-1:0]   s;
    logic [SUM_W-1:0] sum;
    rec_t             r;
    s   = S_W'(p) + S_W'(fc);
    sum = SUM_W'(cc) + SUM_W'(s >> FINE_SLOTS_LOG);
    // The sum stays below twice the coarse size, so one subtraction wraps it.
    if (sum >= SUM_W'(COARSE_SLOTS)) begin
      sum = sum - SUM_W'(COARSE_SLOTS);
    end
    r.reload = p;
    if (S_W'(p) < S_W'(FINE_SIZE)) begin
      r.in_coarse = 1'b0;
      r.slot      = SLOT_W'(s[FINE_SLOTS_LOG-1:0]);
      r.fine_off  = '0;
    end else begin
      r.in_coarse = 1'b1;
      r.slot      = SLOT_W'(sum[CW-1:0]);
      r.fine_off  = s[FINE_SLOTS_LOG-1:0];
    end
    return r;
  endfunction

endpackage

// File: sv/tlw_cmd_if.sv
// Command channel of the timing wheel: valid/ready handshake with the command item.
// Depends on tlw_pkg for the field widths.
interface tlw_cmd_if;
  import tlw_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   timer_id;
  logic [PER_W-1:0]  period;

  modport source (output valid, func, timer_id, period, input ready);
  modport sink   (input valid, func, timer_id, period, output ready);
endinterface

// File: sv/tlw_fire_if.sv
// Result channel of the timing wheel: valid/ready handshake with one fired timer.
// Depends on tlw_pkg for the field widths.
interface tlw_fire_if;
  import tlw_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] fired_id;
  logic            last;

  modport source (output valid, fired_id, last, input ready);
  modport sink   (input valid, fired_id, last, output ready);
endinterface

// File: sv/two_level_timing_wheel.sv
// Two-level timing wheel of periodic timers; timer records live in one RAM.
// Start and stop are taken while idle. A tick is accepted, then the scan reads the record
// RAM one record per cycle while results do not stall, then the flush state hands out
// the held final item, if any.
// Each fired timer is held until the next one fires or the scan ends, so the last is
// marked. Synchronous reset disarms all timers and zeroes both cursors; RAM not cleared.
module two_level_timing_wheel (
  input  logic       clk,
  input  logic       rst,
  tlw_cmd_if.sink    cmd,
  tlw_fire_if.source fired
);
  import tlw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [TIMER_COUNT-1:0]    armed;
  logic [FINE_SLOTS_LOG-1:0] fine_cursor;
  logic [CW-1:0]             coarse_cursor;
  logic                      cascade;
  logic [CNT_W-1:0]          rd_cnt;
  logic                      ev_valid;
  logic [TIDX_W-1:0]         ev_idx;

  logic                      cmd_acc;
  logic [IDX_EXT_W-1:0]      id_ext;
  logic                      id_ok;
  logic [TIDX_W-1:0]         id_idx;
  logic                      do_start;
  logic                      do_stop;
  logic                      do_tick;
  logic [FINE_SLOTS_LOG-1:0] fine_next;

  rec_t                      rec_rd;
  logic [REC_W-1:0]          ram_rdata;
  logic                      ram_we;
  logic [TIDX_W-1:0]         ram_waddr;
  rec_t                      ram_wdata;
  logic                      ram_re;

  logic                      ev_armed;
  logic                      casc;
  logic                      in_c_n;
  logic [SLOT_W-1:0]         slot_n;
  logic                      fire_now;
  logic                      stall;
  logic                      advance;
  logic                      scan_we;
  logic                      scan_done;

  emit_req_t                 req;
  emit_sts_t                 sts;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign id_ext    = IDX_EXT_W'(cmd.timer_id);
  assign id_ok     = id_ext < IDX_EXT_W'(TIMER_COUNT);
  assign id_idx    = id_ext[TIDX_W-1:0];

  always_comb begin
    do_start = 1'b0;
    do_stop  = 1'b0;
    do_tick  = 1'b0;
    case (cmd.func)
      FUNC_START: do_start = cmd_acc && id_ok && period_ok(cmd.period);
      FUNC_STOP:  do_stop  = cmd_acc && id_ok;
      FUNC_TICK:  do_tick  = cmd_acc;
      default:    do_tick  = 1'b0;
    endcase
  end

  assign fine_next = fine_cursor + 1'b1;

  // Evaluation of the record from the registered RAM read: cascade, then expiry.
  assign rec_rd   = rec_t'(ram_rdata);
  assign ev_armed = armed[ev_idx];
  assign casc     = cascade && rec_rd.in_coarse && (rec_rd.slot == SLOT_W'(coarse_cursor));
  assign in_c_n   = casc ? 1'b0 : rec_rd.in_coarse;
  assign slot_n   = casc ? SLOT_W'(rec_rd.fine_off) : rec_rd.slot;
  assign fire_now = ev_valid && ev_armed && !in_c_n && (slot_n == SLOT_W'(fine_cursor));
  assign stall    = fire_now && !sts.push_ready;
  assign advance  = (state == S_SCAN) && !stall;
  assign ram_re   = advance && (rd_cnt < CNT_W'(TIMER_COUNT));
  assign scan_we  = advance && ev_valid && ev_armed && (fire_now || casc);
  assign scan_done = advance && (rd_cnt == CNT_W'(TIMER_COUNT)) && !ev_valid;

  always_comb begin
    ram_we    = do_start || scan_we;
    ram_waddr = do_start ? id_idx : ev_idx;
    if (do_start) begin
      ram_wdata = place(cmd.period, fine_cursor, coarse_cursor);
    end else if (fire_now) begin
      ram_wdata = place(rec_rd.reload, fine_cursor, coarse_cursor);
    end else begin
      ram_wdata           = rec_rd;
      ram_wdata.in_coarse = in_c_n;
      ram_wdata.slot      = slot_n;
    end
  end

  tlw_ram #(
    .WIDTH(REC_W),
    .DEPTH(TIMER_COUNT)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_cnt[TIDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign req.push  = fire_now && sts.push_ready;
  assign req.id    = ID_W'(ev_idx);
  assign req.flush = (state == S_FLUSH);

  tlw_emit u_emit (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .sts   (sts),
    .fired (fired)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (do_tick) state_next = S_SCAN;
      S_SCAN:  if (scan_done) state_next = S_FLUSH;
      S_FLUSH: if (!sts.pend_valid) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      armed         <= '0;
      fine_cursor   <= '0;
      coarse_cursor <= '0;
      cascade       <= 1'b0;
      rd_cnt        <= '0;
      ev_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (do_start) begin
        armed[id_idx] <= 1'b1;
      end else if (do_stop) begin
        armed[id_idx] <= 1'b0;
      end
      if (do_tick) begin
        fine_cursor <= fine_next;
        cascade     <= (fine_next == '0);
        if (fine_next == '0) begin
          if (coarse_cursor == CW'(COARSE_SLOTS - 1)) begin
            coarse_cursor <= '0;
          end else begin
            coarse_cursor <= coarse_cursor + 1'b1;
          end
        end
        rd_cnt   <= '0;
        ev_valid <= 1'b0;
      end else if (advance) begin
        if (ram_re) begin
          rd_cnt <= rd_cnt + 1'b1;
        end
        ev_valid <= ram_re;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_idx <= rd_cnt[TIDX_W-1:0];
    end
  end

  a_no_write_on_stall: assert property (@(posedge clk) disable iff (rst)
    stall |-> !ram_we)
    else $error("record written back while the scan is stalled");

  a_no_same_entry_rw: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != rd_cnt[TIDX_W-1:0]))
    else $error("record read and written at the same entry");

  a_tick_starts_scan: assert property (@(posedge clk) disable iff (rst)
    do_tick |=> (state == S_SCAN) && (rd_cnt == '0) && !ev_valid)
    else $error("tick did not restart the scan");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !sts.pend_valid && !ev_valid)
    else $error("idle with a fired timer still held");
endmodule

// File: sv/tlw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tlw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: sv/tlw_emit.sv
// Result emitter: holds back one fired timer so the last one of a tick can be marked,
// and drives the registered result channel. Depends on tlw_pkg and tlw_fire_if.
module tlw_emit (
  input  logic                clk,
  input  logic                rst,
  input  tlw_pkg::emit_req_t  req,
  output tlw_pkg::emit_sts_t  sts,
  tlw_fire_if.source          fired
);
  import tlw_pkg::*;

  logic            pend_valid;
  logic [ID_W-1:0] pend_id;
  logic            out_valid;
  logic [ID_W-1:0] out_id;
  logic            out_last;
  logic            out_free;
  logic            load_push;
  logic            load_flush;

  assign out_free   = !out_valid || fired.ready;
  assign load_push  = req.push && pend_valid;
  assign load_flush = req.flush && pend_valid && out_free;

  assign sts.push_ready = !pend_valid || out_free;
  assign sts.pend_valid = pend_valid;

  assign fired.valid    = out_valid;
  assign fired.fired_id = out_id;
  assign fired.last     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (req.push) begin
        pend_valid <= 1'b1;
      end else if (load_flush) begin
        pend_valid <= 1'b0;
      end
      if (load_push || load_flush) begin
        out_valid <= 1'b1;
      end else if (fired.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      pend_id <= req.id;
    end
    if (load_push || load_flush) begin
      out_id   <= pend_id;
      out_last <= load_flush;
    end
  end

  a_no_push_and_flush: assert property (@(posedge clk) disable iff (rst)
    !(req.push && req.flush))
    else $error("push and flush requested together");

  a_push_only_when_ready: assert property (@(posedge clk) disable iff (rst)
    req.push |-> sts.push_ready)
    else $error("push while the emitter cannot take it");

  a_flush_marks_last: assert property (@(posedge clk) disable iff (rst)
    load_flush |=> out_valid && out_last && !pend_valid)
    else $error("flush did not produce a final item");
endmodule

// File: verif/tlw_wheel_checker.sv
// Checker for the two-level timing wheel: watches the command and result channels,
// keeps its own timer state to predict the fired timers, and counts mismatches.
// Depends on tlw_pkg, tlw_cmd_if and tlw_fire_if.
module tlw_wheel_checker
  import tlw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tlw_cmd_if   cmd,
  tlw_fire_if  fired,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            last;
  } fire_t;

  fire_t fires_due[$];

  logic                      armed_q   [TIMER_COUNT];
  logic [PER_W-1:0]          reload_q  [TIMER_COUNT];
  logic                      coarse_q  [TIMER_COUNT];
  logic [SLOT_W-1:0]         slot_q    [TIMER_COUNT];
  logic [FINE_SLOTS_LOG-1:0] fine_off_q[TIMER_COUNT];
  logic [FINE_SLOTS_LOG-1:0] fine_pos;
  logic [CW-1:0]             coarse_pos;
  int                        err_count = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic void log_error(string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endfunction

  // Places a timer relative to the current cursors. Periods shorter than one
  // fine turn go straight into the fine wheel.
  function automatic void arm_timer(int id, logic [PER_W-1:0] per);
    int s;
    s = int'(per) + int'(fine_pos);
    armed_q[id]  = 1'b1;
    reload_q[id] = per;
    if (int'(per) < FINE_SIZE) begin
      coarse_q[id]   = 1'b0;
      slot_q[id]     = SLOT_W'(s % FINE_SIZE);
      fine_off_q[id] = '0;
    end else begin
      coarse_q[id]   = 1'b1;
      fine_off_q[id] = FINE_SLOTS_LOG'(s % FINE_SIZE);
      slot_q[id]     = SLOT_W'((int'(coarse_pos) + s / FINE_SIZE) % COARSE_SLOTS);
    end
  endfunction

  function automatic void run_tick();
    logic due [TIMER_COUNT];
    int   last_id;
    fine_pos = fine_pos + 1'b1;
    if (fine_pos == '0) begin
      coarse_pos = CW'((int'(coarse_pos) + 1) % COARSE_SLOTS);
      for (int i = 0; i < TIMER_COUNT; i++) begin
        if (armed_q[i] && coarse_q[i] && slot_q[i] == SLOT_W'(coarse_pos)) begin
          coarse_q[i] = 1'b0;
          slot_q[i]   = SLOT_W'(fine_off_q[i]);
        end
      end
    end
    // Decide who fires before re-arming anyone, so that a timer re-armed
    // into the current slot waits for the next turn.
    last_id = -1;
    for (int i = 0; i < TIMER_COUNT; i++) begin
      due[i] = armed_q[i] && !coarse_q[i] && slot_q[i] == SLOT_W'(fine_pos);
      if (due[i]) begin
        last_id = i;
      end
    end
    for (int i = 0; i < TIMER_COUNT; i++) begin
      if (due[i]) begin
        fires_due.push_back('{id: ID_W'(i), last: (i == last_id)});
        arm_timer(i, reload_q[i]);
      end
    end
  endfunction

  always @(posedge clk) begin
    fire_t want;
    int    tid;
    if (rst) begin
      fires_due.delete();
      fine_pos   = '0;
      coarse_pos = '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        armed_q[i] = 1'b0;
      end
    end else begin
      if (fired.valid && fired.ready) begin
        if (fires_due.size() == 0) begin
          log_error($sformatf("unexpected fired timer %0d, last %0b",
                              fired.fired_id, fired.last));
        end else begin
          want = fires_due.pop_front();
          if (fired.fired_id !== want.id || fired.last !== want.last) begin
            log_error($sformatf("fired timer mismatch: expected id %0d last %0b, got id %0d last %0b",
                                want.id, want.last, fired.fired_id, fired.last));
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        tid = int'(cmd.timer_id);
        case (cmd.func)
          FUNC_START: begin
            if (tid < TIMER_COUNT && cmd.period != '0 && int'(cmd.period) < SPAN) begin
              arm_timer(tid, cmd.period);
            end
          end
          FUNC_STOP: begin
            if (tid < TIMER_COUNT) begin
              armed_q[tid] = 1'b0;
            end
          end
          FUNC_TICK: begin
            run_tick();
          end
          default: begin
          end
        endcase
      end
    end
    mismatches <= err_count;
    pending    <= fires_due.size();
  end

endmodule

// File: verif/two_level_timing_wheel_tb.sv
// Top of the timing wheel testbench: clock, reset, command stimulus and result
// back-pressure, with the checker beside the block. Depends on tlw_pkg, both
// channel interfaces, two_level_timing_wheel and tlw_wheel_checker.
module two_level_timing_wheel_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlw_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int HOLD_CYCLES      = 600;
  localparam int DRAIN_CYCLES     = 100;
  localparam int RANDOM_PER_PHASE = 95;
  localparam int TIMEOUT_NS       = 5_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int mismatch_count;
  int fires_pending;

  int idle_tab[4]  = '{0, 76, 0, 24};
  int stall_tab[4] = '{0, 0, 76, 24};

  tlw_cmd_if  cmd_ch ();
  tlw_fire_if fire_ch ();

  two_level_timing_wheel u_top (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_ch),
    .fired (fire_ch)
  );

  tlw_wheel_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .fired      (fire_ch),
    .mismatches (mismatch_count),
    .pending    (fires_pending)
  );

  always #5 clk = ~clk;

  // Result side: random stalls, plus a long hold-off whenever one is asked for.
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      fire_ch.ready <= 1'b0;
    end else begin
      fire_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_cmd(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
                          input logic [PER_W-1:0] per);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && gap < 40 && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.func     <= fn;
    cmd_ch.timer_id <= id;
    cmd_ch.period   <= per;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly short periods so that timers fire often; some straddle the
  // fine/coarse boundary so that the coarse cascade gets exercised.
  function automatic logic [PER_W-1:0] random_period();
    case ($urandom_range(9))
      5:       return PER_W'($urandom_range(1, FINE_SIZE - 1));
      6, 7:    return PER_W'($urandom_range(FINE_SIZE - 8, 3 * FINE_SIZE));
      8:       return PER_W'($urandom);
      9: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return PER_W'(SPAN - 1);
          2:       return PER_W'(FINE_SIZE - 1);
          default: return PER_W'(FINE_SIZE);
        endcase
      end
      default: return PER_W'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 58) begin
      send_cmd(FUNC_TICK, ID_W'($urandom), PER_W'($urandom));
    end else if (pick < 86) begin
      send_cmd(FUNC_START, ID_W'($urandom_range(TIMER_COUNT - 1)), random_period());
    end else if (pick < 96) begin
      send_cmd(FUNC_STOP, ID_W'($urandom_range(TIMER_COUNT - 1)), PER_W'($urandom));
    end else begin
      send_cmd(FUNC_UNUSED, ID_W'($urandom), PER_W'($urandom));
    end
  endtask

  initial begin
    cmd_ch.valid    = 1'b0;
    cmd_ch.func     = FUNC_TICK;
    cmd_ch.timer_id = '0;
    cmd_ch.period   = '0;
    fire_ch.ready   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items: field extremes, ignored requests, restart, firing order.
    send_cmd(FUNC_START, ID_W'(0), PER_W'(1));
    send_cmd(FUNC_START, ID_W'(31), PER_W'(FINE_SIZE - 1));
    send_cmd(FUNC_START, ID_W'(5), PER_W'(FINE_SIZE));
    send_cmd(FUNC_START, ID_W'(6), PER_W'(SPAN - 1));
    send_cmd(FUNC_START, ID_W'(7), PER_W'(0));
    send_cmd(FUNC_STOP, ID_W'(9), PER_W'(0));
    send_cmd(FUNC_UNUSED, '1, '1);
    send_cmd(FUNC_START, ID_W'(1), PER_W'(2));
    send_cmd(FUNC_START, ID_W'(2), PER_W'(2));
    send_cmd(FUNC_START, ID_W'(2), PER_W'(0));
    send_cmd(FUNC_TICK, '0, '0);
    send_cmd(FUNC_TICK, '1, '1);
    send_cmd(FUNC_START, ID_W'(1), PER_W'(3));
    send_cmd(FUNC_STOP, ID_W'(0), PER_W'(0));
    send_cmd(FUNC_TICK, '0, '0);
    send_cmd(FUNC_TICK, '0, '0);
    send_cmd(FUNC_TICK, '0, '0);
    send_cmd(FUNC_STOP, ID_W'(2), PER_W'(0));
    send_cmd(FUNC_STOP, ID_W'(1), PER_W'(0));
    send_cmd(FUNC_START, ID_W'(3), PER_W'(1));
    send_cmd(FUNC_TICK, '0, '0);
    send_cmd(FUNC_STOP, ID_W'(3), PER_W'(0));

    // Every timer fires on every tick while the result side is held off,
    // so the block must stall its command input until the hold ends.
    hold_asked++;
    for (int i = 0; i < TIMER_COUNT; i++) begin
      send_cmd(FUNC_START, ID_W'(i), PER_W'(1));
    end
    repeat (4) send_cmd(FUNC_TICK, '0, '0);
    for (int i = 0; i < TIMER_COUNT; i++) begin
      send_cmd(FUNC_STOP, ID_W'(i), PER_W'(0));
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      repeat (RANDOM_PER_PHASE) send_random_item();
    end
    cmd_ch.valid <= 1'b0;

    while (fires_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && fires_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout: the run did not complete");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
